// File: rtl/vscd_pkg.sv
`default_nettype none

package vscd_pkg;

    localparam int MAX_TILES_DEF = 8192;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int TDIFF_W = 10;
    localparam int LUMA_W  = 8;
    localparam int LPROD_W = 16;
    localparam int SQ_W    = 16;

    localparam int DSUM_W = 23;
    localparam int LSUM_W = 21;
    localparam int QSUM_W = 30;

    localparam int TC_W       = 14;
    localparam int LVL_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [LPROD_W-1:0] COEF_R     = 16'd54;
    localparam logic [LPROD_W-1:0] COEF_G     = 16'd183;
    localparam logic [LPROD_W-1:0] COEF_B     = 16'd19;
    localparam logic [LPROD_W-1:0] LUMA_ROUND = 16'd128;

    localparam logic [TC_W-1:0]  TILE_COUNT_RST = 14'd4800;
    localparam logic [LVL_W-1:0] CUT_LEVEL_RST  = 12'd800;
    localparam logic [LVL_W-1:0] FADE_LEVEL_RST = 12'd21;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NS_W   = TC_W + QSUM_W;
    localparam int LN_W   = LVL_W + TC_W;
    localparam int BASE_W = 29;
    localparam int BSQ_W  = 2 * BASE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_COUNT = 2'd0,
        CFG_CUT_LEVEL  = 2'd1,
        CFG_FADE_LEVEL = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TC_W-1:0]  tile_count;
        logic [LVL_W-1:0] cut_level;
        logic [LVL_W-1:0] fade_level;
    } cfg_t;

    typedef struct packed {
        logic              prime;
        logic [DSUM_W-1:0] diff;
        logic [LSUM_W-1:0] luma;
        logic [QSUM_W-1:0] sq;
    } frame_rec_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_BASE,
        BK_SQUARE,
        BK_DECIDE
    } back_state_t;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// File: rtl/vscd_tile_if.sv
`default_nettype none

interface vscd_tile_if;
    logic                         valid;
    logic                         ready;
    logic [vscd_pkg::COLOR_W-1:0] tile_color;
    logic                         last_tile;
    logic                         restart;

    modport source (output valid, output tile_color, output last_tile, output restart,
                    input ready);
    modport sink (input valid, input tile_color, input last_tile, input restart,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/vscd_result_if.sv
`default_nettype none

interface vscd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        scene_change;
    logic                        fade_seen;
    logic                        primed_only;
    logic [vscd_pkg::DSUM_W-1:0] frame_difference;
    logic [vscd_pkg::LSUM_W-1:0] luma_total;

    modport source (output valid, output scene_change, output fade_seen, output primed_only,
                    output frame_difference, output luma_total, input ready);
    modport sink (input valid, input scene_change, input fade_seen, input primed_only,
                  input frame_difference, input luma_total, output ready);
endinterface

`default_nettype wire

// File: rtl/video_scene_change_detector.sv
// Scene change detector over a stream of tile averages.
// tile: one transaction per tile (tile_color, last_tile, restart), valid/ready.
// result: one transaction per frame, issued for the last_tile transaction.
// cfg_write/cfg_index/cfg_data: write-only register port, written while idle.
// Tiles are taken one per cycle while tile ready is high; each does one
// read-modify-write of the tile store at its tile index, so the store
// port sets that figure. The frame-end test runs in a sequencer (idle,
// multiply, base, square, decide; a priming frame skips to decide) behind
// a four-entry frame queue; tile ready drops only when queued and in-flight
// frame ends fill that queue. The last tile passes stages s1 and s2 before
// its frame's record is queued; decide loads the result register once free.
// A stalled receiver holds the result register; tiles keep flowing until the
// frame queue is full.
// Reset clears the sums, the tile index and the fade state and loads the
// default thresholds; the tile store is not cleared, the first frame after
// reset only loads it, so no clearing pass is needed.
`default_nettype none

module video_scene_change_detector #(
    parameter int MAX_TILES = vscd_pkg::MAX_TILES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    vscd_tile_if.sink                              tile,
    vscd_result_if.source                          result,
    input  wire logic                              cfg_write,
    input  wire logic [vscd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vscd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vscd_pkg::cfg_t       cfg_reg;
    vscd_pkg::frame_rec_t push_rec;
    vscd_pkg::frame_rec_t head;
    vscd_pkg::q_stat_t    q_stat;
    logic                 q_push;
    logic                 q_pop;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.tile_count <= vscd_pkg::TILE_COUNT_RST;
            cfg_reg.cut_level  <= vscd_pkg::CUT_LEVEL_RST;
            cfg_reg.fade_level <= vscd_pkg::FADE_LEVEL_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                vscd_pkg::CFG_TILE_COUNT: cfg_reg.tile_count <= cfg_data;
                vscd_pkg::CFG_CUT_LEVEL:  cfg_reg.cut_level  <= cfg_data[vscd_pkg::LVL_W-1:0];
                vscd_pkg::CFG_FADE_LEVEL: cfg_reg.fade_level <= cfg_data[vscd_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    vscd_front #(
        .MAX_TILES (MAX_TILES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tile     (tile),
        .q_stat   (q_stat),
        .push     (q_push),
        .push_rec (push_rec)
    );

    vscd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    vscd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .result (result)
    );

    // credit check in the front must keep the frame queue from overflowing
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_stat.count < vscd_pkg::QCNT_W'(vscd_pkg::QUEUE_DEPTH)))
        else $error("frame queue push while full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("frame queue pop while empty");

    a_prime_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.primed_only) |->
            (!result.scene_change && !result.fade_seen &&
             result.frame_difference == '0 && result.luma_total == '0))
        else $error("priming frame result carries measurements");

endmodule

`default_nettype wire

// File: rtl/vscd_front.sv
`default_nettype none

module vscd_front #(
    parameter int MAX_TILES = vscd_pkg::MAX_TILES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    vscd_tile_if.sink             tile,
    input  wire vscd_pkg::q_stat_t q_stat,
    output logic                  push,
    output vscd_pkg::frame_rec_t  push_rec
);

    localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TILES - 1);
    localparam int USED_W = vscd_pkg::QCNT_W + 1;

    logic [vscd_pkg::COLOR_W-1:0] store [MAX_TILES];

    logic [IDX_W-1:0] tile_index_reg;
    logic             have_prev_reg;
    logic             priming_reg;

    logic s1_valid_reg, s1_last_reg, s1_prime_reg;
    logic s2_valid_reg, s2_last_reg, s2_prime_reg;

    logic [vscd_pkg::COLOR_W-1:0] color1_reg;
    logic [vscd_pkg::COLOR_W-1:0] prev_reg;
    logic [vscd_pkg::TDIFF_W-1:0] d2_reg;
    logic [vscd_pkg::LUMA_W-1:0]  lum2_reg;

    logic [vscd_pkg::DSUM_W-1:0] diff_sum_reg, diff_sum_next;
    logic [vscd_pkg::LSUM_W-1:0] luma_sum_reg, luma_sum_next;
    logic [vscd_pkg::QSUM_W-1:0] sq_sum_reg, sq_sum_next;

    logic             accept;
    logic             prime_now;
    logic [1:0]       pending;
    logic [USED_W-1:0] used;

    logic [vscd_pkg::CHAN_W-1:0]  r1, g1, b1;
    logic [vscd_pkg::TDIFF_W-1:0] d1;
    logic [vscd_pkg::LPROD_W-1:0] luma_wide;

    logic [vscd_pkg::SQ_W-1:0]   sq2;
    logic [vscd_pkg::DSUM_W:0]   dsum_wide;
    logic [vscd_pkg::LSUM_W:0]   lsum_wide;
    logic [vscd_pkg::QSUM_W:0]   qsum_wide;

    // frame ends still in the pipeline hold a queue slot each
    assign pending = {1'b0, s1_valid_reg && s1_last_reg} + {1'b0, s2_valid_reg && s2_last_reg};
    assign used    = USED_W'(q_stat.count) + USED_W'(pending);
    assign tile.ready = (used < USED_W'(vscd_pkg::QUEUE_DEPTH));
    assign accept  = tile.valid && tile.ready;

    assign prime_now = ((tile_index_reg == '0) ? !have_prev_reg : priming_reg) || tile.restart;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tile_index_reg <= '0;
            have_prev_reg  <= 1'b0;
            priming_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_prime_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            s2_prime_reg   <= 1'b0;
            diff_sum_reg   <= '0;
            luma_sum_reg   <= '0;
            sq_sum_reg     <= '0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            s2_prime_reg <= s1_prime_reg;
            if (accept) begin
                s1_last_reg  <= tile.last_tile;
                s1_prime_reg <= prime_now;
                if (tile.last_tile) begin
                    tile_index_reg <= '0;
                    have_prev_reg  <= 1'b1;
                    priming_reg    <= 1'b0;
                end else begin
                    priming_reg <= prime_now;
                    if (tile_index_reg != IDX_LAST) begin
                        tile_index_reg <= tile_index_reg + IDX_W'(1);
                    end
                end
            end
            if (s2_valid_reg) begin
                diff_sum_reg <= diff_sum_next;
                luma_sum_reg <= luma_sum_next;
                sq_sum_reg   <= sq_sum_next;
            end
        end
    end

    // read-first store: each transaction reads its entry and writes the new color over it
    always_ff @(posedge clk) begin
        if (accept) begin
            prev_reg              <= store[tile_index_reg];
            store[tile_index_reg] <= tile.tile_color;
            color1_reg            <= tile.tile_color;
        end
    end

    always_comb begin
        r1 = color1_reg[23:16];
        g1 = color1_reg[15:8];
        b1 = color1_reg[7:0];
        d1 = vscd_pkg::TDIFF_W'(vscd_pkg::absdiff(r1, prev_reg[23:16]))
           + vscd_pkg::TDIFF_W'(vscd_pkg::absdiff(g1, prev_reg[15:8]))
           + vscd_pkg::TDIFF_W'(vscd_pkg::absdiff(b1, prev_reg[7:0]));
        luma_wide = vscd_pkg::LPROD_W'(r1) * vscd_pkg::COEF_R
                  + vscd_pkg::LPROD_W'(g1) * vscd_pkg::COEF_G
                  + vscd_pkg::LPROD_W'(b1) * vscd_pkg::COEF_B
                  + vscd_pkg::LUMA_ROUND;
    end

    always_ff @(posedge clk) begin
        if (s1_valid_reg) begin
            d2_reg   <= d1;
            lum2_reg <= luma_wide[15:8];
        end
    end

    always_comb begin
        sq2       = vscd_pkg::SQ_W'(lum2_reg) * vscd_pkg::SQ_W'(lum2_reg);
        dsum_wide = {1'b0, diff_sum_reg} + (vscd_pkg::DSUM_W + 1)'(d2_reg);
        lsum_wide = {1'b0, luma_sum_reg} + (vscd_pkg::LSUM_W + 1)'(lum2_reg);
        qsum_wide = {1'b0, sq_sum_reg} + (vscd_pkg::QSUM_W + 1)'(sq2);

        push_rec.prime = s2_prime_reg;
        push_rec.diff  = dsum_wide[vscd_pkg::DSUM_W] ? '1 : dsum_wide[vscd_pkg::DSUM_W-1:0];
        push_rec.luma  = lsum_wide[vscd_pkg::LSUM_W] ? '1 : lsum_wide[vscd_pkg::LSUM_W-1:0];
        push_rec.sq    = qsum_wide[vscd_pkg::QSUM_W] ? '1 : qsum_wide[vscd_pkg::QSUM_W-1:0];

        push = s2_valid_reg && s2_last_reg;

        if (s2_last_reg) begin
            diff_sum_next = '0;
            luma_sum_next = '0;
            sq_sum_next   = '0;
        end else begin
            diff_sum_next = push_rec.diff;
            luma_sum_next = push_rec.luma;
            sq_sum_next   = push_rec.sq;
        end
    end

endmodule

`default_nettype wire

// File: rtl/vscd_queue.sv
`default_nettype none

module vscd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire vscd_pkg::frame_rec_t push_rec,
    input  wire logic             pop,
    output vscd_pkg::frame_rec_t  head,
    output vscd_pkg::q_stat_t     q_stat
);

    localparam logic [vscd_pkg::QPTR_W-1:0] PTR_LAST =
        vscd_pkg::QPTR_W'(vscd_pkg::QUEUE_DEPTH - 1);

    vscd_pkg::frame_rec_t entries [vscd_pkg::QUEUE_DEPTH];

    logic [vscd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [vscd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [vscd_pkg::QCNT_W-1:0] count_reg;

    assign head         = entries[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/vscd_back.sv
`default_nettype none

module vscd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vscd_pkg::cfg_t   cfg,
    input  wire vscd_pkg::frame_rec_t head,
    input  wire vscd_pkg::q_stat_t q_stat,
    output logic                  pop,
    vscd_result_if.source         result
);

    vscd_pkg::back_state_t state_reg, state_next;

    vscd_pkg::frame_rec_t            rec_reg;
    logic [vscd_pkg::NS_W-1:0]       p_ns_reg;
    logic [vscd_pkg::LN_W-1:0]       p_fn_reg;
    logic [vscd_pkg::LN_W-1:0]       p_cn_reg;
    logic [vscd_pkg::BASE_W-1:0]     base_reg;
    logic [vscd_pkg::BSQ_W-1:0]      sq_reg;
    logic                            cut_reg;

    logic in_fade_reg, in_fade_next;
    logic first_cmp_reg, first_cmp_next;

    logic                        out_valid_reg;
    logic                        out_change_reg;
    logic                        out_fade_reg;
    logic                        out_prime_reg;
    logic [vscd_pkg::DSUM_W-1:0] out_diff_reg;
    logic [vscd_pkg::LSUM_W-1:0] out_luma_reg;

    logic out_free;
    logic out_load;
    logic fade;
    logic change;

    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= vscd_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            vscd_pkg::BK_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    state_next = head.prime ? vscd_pkg::BK_DECIDE : vscd_pkg::BK_MUL;
                end
            end
            vscd_pkg::BK_MUL:    state_next = vscd_pkg::BK_BASE;
            vscd_pkg::BK_BASE:   state_next = vscd_pkg::BK_SQUARE;
            vscd_pkg::BK_SQUARE: state_next = vscd_pkg::BK_DECIDE;
            vscd_pkg::BK_DECIDE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = vscd_pkg::BK_IDLE;
                end
            end
            default: state_next = vscd_pkg::BK_IDLE;
        endcase
    end

    // 256*N*S2 < (16*S1 + 3*F*N)^2
    always_ff @(posedge clk) begin
        if (pop) begin
            rec_reg <= head;
        end
        if (state_reg == vscd_pkg::BK_MUL) begin
            p_ns_reg <= vscd_pkg::NS_W'(cfg.tile_count) * vscd_pkg::NS_W'(rec_reg.sq);
            p_fn_reg <= vscd_pkg::LN_W'(cfg.fade_level) * vscd_pkg::LN_W'(cfg.tile_count);
            p_cn_reg <= vscd_pkg::LN_W'(cfg.cut_level) * vscd_pkg::LN_W'(cfg.tile_count);
        end
        if (state_reg == vscd_pkg::BK_BASE) begin
            base_reg <= vscd_pkg::BASE_W'({rec_reg.luma, 4'b0000})
                      + vscd_pkg::BASE_W'({p_fn_reg, 1'b0})
                      + vscd_pkg::BASE_W'(p_fn_reg);
            cut_reg  <= vscd_pkg::LN_W'(rec_reg.diff) > (p_cn_reg >> 4);
        end
        if (state_reg == vscd_pkg::BK_SQUARE) begin
            sq_reg <= vscd_pkg::BSQ_W'(base_reg) * vscd_pkg::BSQ_W'(base_reg);
        end
    end

    always_comb begin
        fade           = vscd_pkg::BSQ_W'({p_ns_reg, 8'h00}) < sq_reg;
        change         = cut_reg;
        in_fade_next   = in_fade_reg;
        first_cmp_next = first_cmp_reg;
        if (first_cmp_reg) begin
            in_fade_next   = fade;
            first_cmp_next = 1'b0;
        end else if (!in_fade_reg && fade) begin
            in_fade_next = 1'b1;
            change       = 1'b1;
        end else if (in_fade_reg && !fade) begin
            in_fade_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_fade_reg   <= 1'b0;
            first_cmp_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                if (!rec_reg.prime) begin
                    in_fade_reg   <= in_fade_next;
                    first_cmp_reg <= first_cmp_next;
                end
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            if (rec_reg.prime) begin
                out_change_reg <= 1'b0;
                out_fade_reg   <= 1'b0;
                out_prime_reg  <= 1'b1;
                out_diff_reg   <= '0;
                out_luma_reg   <= '0;
            end else begin
                out_change_reg <= change;
                out_fade_reg   <= fade;
                out_prime_reg  <= 1'b0;
                out_diff_reg   <= rec_reg.diff;
                out_luma_reg   <= rec_reg.luma;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.scene_change     = out_change_reg;
    assign result.fade_seen        = out_fade_reg;
    assign result.primed_only      = out_prime_reg;
    assign result.frame_difference = out_diff_reg;
    assign result.luma_total       = out_luma_reg;

endmodule

`default_nettype wire

// File: test/tb_video_scene_change_detector.sv
`timescale 1ns / 1ps

module tb_video_scene_change_detector;
    import vscd_pkg::*;

    localparam int STORE_DEPTH   = MAX_TILES_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_FRAME    = 150;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TILES   = 60;

    localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BLACK = 24'h000000;

    localparam longint unsigned DIFF_CAP   = (64'd1 << DSUM_W) - 1;
    localparam longint unsigned LUMA_CAP   = (64'd1 << LSUM_W) - 1;
    localparam longint unsigned SQUARE_CAP = (64'd1 << QSUM_W) - 1;

    typedef enum int {
        PAT_NOISE,
        PAT_FLAT,
        PAT_STILL,
        PAT_EXTREME
    } tile_pattern_t;

    typedef struct {
        logic              scene_change;
        logic              fade_seen;
        logic              primed_only;
        logic [DSUM_W-1:0] frame_difference;
        logic [LSUM_W-1:0] luma_total;
    } frame_verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vscd_tile_if   tile();
    vscd_result_if result();

    video_scene_change_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tile      (tile),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scene predictor state
    bit   [COLOR_W-1:0] prior_colors [STORE_DEPTH];
    int unsigned        tile_pos;
    int unsigned        stored_len;
    logic [DSUM_W-1:0]  diff_acc;
    logic [LSUM_W-1:0]  luma_acc;
    logic [QSUM_W-1:0]  square_acc;
    bit                 have_frame;
    bit                 first_cmp;
    bit                 fading;
    bit                 priming;
    logic [TC_W-1:0]    tiles_per_frame;
    logic [LVL_W-1:0]   cut_thresh;
    logic [LVL_W-1:0]   fade_thresh;

    frame_verdict_t verdict_q[$];
    int             mismatches;
    bit             burst_mode;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("tb_video_scene_change_detector: done, errors");
        $finish;
    end

    function automatic longint unsigned clamp_to(longint unsigned v, longint unsigned cap);
        return (v > cap) ? cap : v;
    endfunction

    function automatic int unsigned chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic logic [COLOR_W-1:0] jitter_color(logic [COLOR_W-1:0] color);
        logic [COLOR_W-1:0] res;
        int                 ch;
        int                 v;
        for (ch = 0; ch < 3; ch++)
        begin
            v = int'(color[ch*CHAN_W +: CHAN_W]) + int'($urandom_range(2)) - 1;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            res[ch*CHAN_W +: CHAN_W] = CHAN_W'(v);
        end
        return res;
    endfunction

    function automatic logic [COLOR_W-1:0] next_color(tile_pattern_t pat,
                                                      logic [COLOR_W-1:0] anchor,
                                                      int unsigned pos);
        int unsigned slot;
        slot = (pos < STORE_DEPTH) ? pos : STORE_DEPTH - 1;
        case (pat)
            PAT_FLAT:    return jitter_color(anchor);
            PAT_STILL:   return (slot < stored_len) ? jitter_color(prior_colors[slot])
                                                    : COLOR_W'($urandom);
            PAT_EXTREME: return $urandom_range(1) ? WHITE : BLACK;
            default:     return COLOR_W'($urandom);
        endcase
    endfunction

    task automatic predict_tile(logic [COLOR_W-1:0] color, bit last, bit restart_flag);
        logic [COLOR_W-1:0] old;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        int unsigned        d;
        int unsigned        lum;
        longint unsigned    lhs;
        longint unsigned    base;
        longint unsigned    cut_limit;
        bit                 fade;
        bit                 cut;
        frame_verdict_t     v;
        old = prior_colors[tile_pos];
        r = color[23:16];
        g = color[15:8];
        b = color[7:0];
        if (tile_pos == 0)
            priming = !have_frame;
        if (restart_flag)
            priming = 1'b1;
        d = chan_gap(r, old[23:16]) + chan_gap(g, old[15:8]) + chan_gap(b, old[7:0]);
        lum = (r * COEF_R + g * COEF_G + b * COEF_B + LUMA_ROUND) >> 8;
        diff_acc   = DSUM_W'(clamp_to(longint'(diff_acc) + d, DIFF_CAP));
        luma_acc   = LSUM_W'(clamp_to(longint'(luma_acc) + lum, LUMA_CAP));
        square_acc = QSUM_W'(clamp_to(longint'(square_acc) + lum * lum, SQUARE_CAP));
        prior_colors[tile_pos] = color;
        if (tile_pos + 1 > stored_len)
            stored_len = tile_pos + 1;
        if (!last)
        begin
            // extra tiles past the store keep hitting the last entry
            if (tile_pos < STORE_DEPTH - 1)
                tile_pos++;
            return;
        end
        if (priming)
        begin
            have_frame         = 1'b1;
            v.scene_change     = 1'b0;
            v.fade_seen        = 1'b0;
            v.primed_only      = 1'b1;
            v.frame_difference = '0;
            v.luma_total       = '0;
        end
        else
        begin
            lhs  = 64'd256 * longint'(tiles_per_frame) * longint'(square_acc);
            base = 64'd16 * longint'(luma_acc)
                   + 64'd3 * longint'(fade_thresh) * longint'(tiles_per_frame);
            fade = lhs < base * base;
            cut_limit = (longint'(cut_thresh) * longint'(tiles_per_frame)) >> 4;
            cut = longint'(diff_acc) > cut_limit;
            v.scene_change = cut;
            if (first_cmp)
            begin
                fading    = fade;
                first_cmp = 1'b0;
            end
            else if (!fading && fade)
            begin
                fading         = 1'b1;
                v.scene_change = 1'b1;
            end
            else if (fading && !fade)
                fading = 1'b0;
            v.fade_seen        = fade;
            v.primed_only      = 1'b0;
            v.frame_difference = diff_acc;
            v.luma_total       = luma_acc;
        end
        verdict_q.push_back(v);
        priming    = 1'b0;
        tile_pos   = 0;
        diff_acc   = '0;
        luma_acc   = '0;
        square_acc = '0;
    endtask

    task automatic send_tile(logic [COLOR_W-1:0] color, bit last, bit restart_flag);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(6);
        @(negedge clk);
        if (gap > 0)
        begin
            tile.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tile.valid      <= 1'b1;
        tile.tile_color <= color;
        tile.last_tile  <= last;
        tile.restart    <= restart_flag;
        do
            @(posedge clk);
        while (!tile.ready);
        predict_tile(color, last, restart_flag);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        tile.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        // tiles of an open frame may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (which)
            CFG_TILE_COUNT: tiles_per_frame = value[TC_W-1:0];
            CFG_CUT_LEVEL:  cut_thresh = value[LVL_W-1:0];
            CFG_FADE_LEVEL: fade_thresh = value[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic play_frame(int len, tile_pattern_t pat, int restart_at);
        logic [COLOR_W-1:0] anchor;
        int                 k;
        anchor = COLOR_W'($urandom);
        for (k = 0; k < len; k++)
            send_tile(next_color(pat, anchor, k), k == len - 1, k == restart_at);
    endtask

    task automatic random_frame(output int len);
        int            pick;
        int            restart_at;
        tile_pattern_t pat;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(8, 1);
        else if (pick < 95)
            len = $urandom_range(40, 9);
        else
            len = $urandom_range(200, 41);
        restart_at = ($urandom_range(9) == 0) ? int'($urandom_range(len - 1)) : -1;
        // a compared frame must stay within the written part of the store
        if (restart_at < 0 && have_frame && len > stored_len)
            len = stored_len;
        pat = tile_pattern_t'($urandom_range(3));
        if ($urandom_range(24) == 0)
            wait_drained();
        play_frame(len, pat, restart_at);
    endtask

    // reset thresholds, priming after reset, then the first comparison
    task automatic test_reset_defaults();
        send_tile(BLACK, 1'b0, 1'b0);
        send_tile(WHITE, 1'b0, 1'b0);
        send_tile(24'h123456, 1'b1, 1'b0);
        send_tile(24'hFF0000, 1'b0, 1'b0);
        send_tile(24'h00FF00, 1'b0, 1'b0);
        send_tile(24'h0000FF, 1'b1, 1'b0);
    endtask

    // fade exit, fade entry, staying in fade, restarts and one-tile frames
    task automatic test_fade_states();
        wait_drained();
        write_reg(CFG_TILE_COUNT, 14'd3);
        write_reg(CFG_CUT_LEVEL, 14'd100);
        write_reg(CFG_FADE_LEVEL, 14'd21);
        send_tile(24'hFF0000, 1'b0, 1'b0);
        send_tile(24'h00FF00, 1'b0, 1'b0);
        send_tile(24'h0000FF, 1'b1, 1'b0);
        repeat (2)
        begin
            send_tile(24'h808080, 1'b0, 1'b0);
            send_tile(24'h808080, 1'b0, 1'b0);
            send_tile(24'h808080, 1'b1, 1'b0);
        end
        send_tile(24'h808080, 1'b0, 1'b0);
        send_tile(BLACK, 1'b0, 1'b1);
        send_tile(WHITE, 1'b1, 1'b0);
        send_tile(24'h5A5A5A, 1'b1, 1'b1);
        send_tile(24'hA5A5A5, 1'b1, 1'b0);
    endtask

    // long frames of extreme colors at the largest thresholds, then a flat one
    task automatic test_long_frames();
        int k;
        wait_drained();
        write_reg(CFG_TILE_COUNT, 14'd8192);
        write_reg(CFG_CUT_LEVEL, 14'd4095);
        write_reg(CFG_FADE_LEVEL, 14'd4095);
        for (k = 0; k < LONG_FRAME; k++)
            send_tile(k[0] ? WHITE : BLACK, k == LONG_FRAME - 1, k == 0);
        burst_mode = 1'b1;
        // opposite color on every tile
        for (k = 0; k < LONG_FRAME; k++)
            send_tile(k[0] ? BLACK : WHITE, k == LONG_FRAME - 1, 1'b0);
        burst_mode = 1'b0;
        for (k = 0; k < LONG_FRAME; k++)
            send_tile(WHITE, k == LONG_FRAME - 1, 1'b0);
    endtask

    task automatic test_random_frames();
        int phase;
        int sent;
        int len;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(CFG_TILE_COUNT, 14'd0);
                    write_reg(CFG_CUT_LEVEL, 14'd0);
                    write_reg(CFG_FADE_LEVEL, 14'd0);
                end
                1:
                begin
                    write_reg(CFG_TILE_COUNT, 14'h3FFF);
                    write_reg(CFG_CUT_LEVEL, 14'h3FFF);
                    write_reg(CFG_FADE_LEVEL, 14'h3FFF);
                end
                2, 3:
                begin
                    write_reg(CFG_TILE_COUNT, (phase == 2) ? 14'd8192 : 14'd1);
                    write_reg(CFG_CUT_LEVEL, CFG_DATA_W'($urandom));
                    write_reg(CFG_FADE_LEVEL, {2'($urandom), 12'($urandom_range(60))});
                end
                default:
                begin
                    write_reg(CFG_TILE_COUNT, CFG_DATA_W'($urandom_range(24, 1)));
                    write_reg(CFG_CUT_LEVEL, {2'($urandom), 12'($urandom_range(1600))});
                    write_reg(CFG_FADE_LEVEL, {2'($urandom), 12'($urandom_range(60))});
                end
            endcase
            burst_mode = (phase % 3 == 2);
            sent = 0;
            while (sent < PHASE_TILES)
            begin
                random_frame(len);
                sent += len;
            end
        end
        burst_mode = 1'b0;
    endtask

    // result sink with random stalls, none in burst mode
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(6);
            @(negedge clk);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
        end
    end

    always @(posedge clk)
    begin
        frame_verdict_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: change %0b fade %0b primed %0b",
                             result.scene_change, result.fade_seen, result.primed_only);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (result.scene_change !== want.scene_change
                    || result.fade_seen !== want.fade_seen
                    || result.primed_only !== want.primed_only
                    || result.frame_difference !== want.frame_difference
                    || result.luma_total !== want.luma_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp change %0b fade %0b primed %0b ",
                                  "diff %0d luma %0d, got %0b %0b %0b %0d %0d"},
                                 want.scene_change, want.fade_seen, want.primed_only,
                                 want.frame_difference, want.luma_total,
                                 result.scene_change, result.fade_seen, result.primed_only,
                                 result.frame_difference, result.luma_total);
                end
            end
        end
    end

    initial begin
        rst_n           = 1'b0;
        tile.valid      = 1'b0;
        tile.tile_color = '0;
        tile.last_tile  = 1'b0;
        tile.restart    = 1'b0;
        result.ready    = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_TILE_COUNT;
        cfg_data        = '0;
        mismatches      = 0;
        burst_mode      = 1'b0;
        tile_pos        = 0;
        stored_len      = 0;
        diff_acc        = '0;
        luma_acc        = '0;
        square_acc      = '0;
        have_frame      = 1'b0;
        first_cmp       = 1'b1;
        fading          = 1'b0;
        priming         = 1'b0;
        tiles_per_frame = TILE_COUNT_RST;
        cut_thresh      = CUT_LEVEL_RST;
        fade_thresh     = FADE_LEVEL_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_fade_states();
        test_long_frames();
        test_random_frames();
        wait_drained();

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("tb_video_scene_change_detector: done, clean");
        else
            $display("tb_video_scene_change_detector: done, errors");
        $finish;
    end

endmodule
